@@ rtl/cba_pkg.sv @@
`timescale 1ns / 1ps

package cba_pkg;

    // Default sizes, handed to the top level parameters
    localparam int CBA_NUM_BLOCKS   = 64;
    localparam int CBA_NUM_FILE_IDS = 16;

    // Fixed field widths of the item ports
    localparam int CFG_W    = 7;
    localparam int ID_W     = 4;
    localparam int SIZE_W   = 7;
    localparam int STATUS_W = 2;
    localparam int START_W  = 6;
    localparam int LEN_W    = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Request modes
    localparam logic MODE_ALLOC  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_CREATED   = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_DONE
    } t_state;

    // Flags from the run unit to the sequencer
    typedef struct packed {
        logic match;   // current owner equals the search key
        logic first;   // no run open yet
    } t_run_flags;

endpackage

@@ rtl/cba_owner_mem.sv @@
`timescale 1ns / 1ps

module cba_owner_mem import cba_pkg::*; #(
    parameter int DEPTH = CBA_NUM_BLOCKS,
    parameter int AW    = 6,
    parameter int DW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Owner table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/cba_run_unit.sv @@
`timescale 1ns / 1ps

module cba_run_unit import cba_pkg::*; #(
    parameter int AW = 6,
    parameter int CW = 7,
    parameter int DW = 5
) (
    input  logic          i_clk,
    input  logic          i_clr,
    input  logic          i_step,
    input  logic [DW-1:0] i_data,
    input  logic [DW-1:0] i_key,
    input  logic [AW-1:0] i_idx,
    output t_run_flags    o_flags,
    output logic [CW-1:0] o_count,
    output logic [CW-1:0] o_count_next,
    output logic [AW-1:0] o_start
);

    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_start, n_start;
    logic          match;
    logic          first;
    logic [CW-1:0] count_inc;
    logic [AW-1:0] start_now;

    // Compare and run count, one owner entry per step
    always_comb begin
        match     = (i_data == i_key);
        first     = (r_count == '0);
        count_inc = r_count + 1'b1;
        start_now = first ? i_idx : r_start;

        n_count = r_count;
        n_start = r_start;
        if (i_clr) begin
            n_count = '0;
        end else if (i_step) begin
            n_count = match ? count_inc : '0;
            if (match) begin
                n_start = start_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= n_count;
        r_start <= n_start;
    end

    assign o_flags.match = match;
    assign o_flags.first = first;
    assign o_count       = r_count;
    assign o_count_next  = count_inc;
    assign o_start       = start_now;

endmodule

@@ rtl/contiguous_block_allocator.sv @@
`timescale 1ns / 1ps

// First-fit contiguous block allocator. An owner table of NUM_BLOCKS entries is kept in a
// single memory and walked one entry per cycle by a shared compare-and-count unit. After
// reset a clearing pass writes every entry free, during which no item is taken
// (configuration writes still land). An allocate item scans for the first run of free
// blocks up to the managed count, reading through the registered read port, then writes
// the run at one block per cycle; a lookup stops at the end of the lowest run of the id.
// Requests that fail the id, size or managed-count checks skip the scan. The owner table
// has one write port and one read port, both addressed by the same block index. One item
// is worked on at a time; a finished result sits in the output register, so the next
// item can be taken while it waits.
module contiguous_block_allocator import cba_pkg::*; #(
    parameter int NUM_BLOCKS   = CBA_NUM_BLOCKS,
    parameter int NUM_FILE_IDS = CBA_NUM_FILE_IDS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_data,
    // request items
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_mode,
    input  logic [ID_W-1:0]     i_file_id,
    input  logic [SIZE_W-1:0]   i_size,
    // result items
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [START_W-1:0]  o_start_block,
    output logic [LEN_W-1:0]    o_run_length
);

    localparam int AW   = $clog2(NUM_BLOCKS);
    localparam int CW   = $clog2(NUM_BLOCKS + 1);
    localparam int DW   = $clog2(NUM_FILE_IDS + 1);
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

    localparam logic [DW-1:0] FREE_KEY  = DW'(NUM_FILE_IDS);
    localparam logic [CW-1:0] LAST_BLK  = CW'(NUM_BLOCKS - 1);

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_cfg;
    logic               r_mode, n_mode;
    logic [DW-1:0]      r_id, n_id;
    logic [CW-1:0]      r_size, n_size;
    logic [CW-1:0]      r_n, n_n;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_left, n_left;
    logic [AW-1:0]      r_chk_idx;
    logic               r_pend;
    t_status            r_res_status, n_res_status;
    logic [AW-1:0]      r_res_start, n_res_start;
    logic [CW-1:0]      r_res_len, n_res_len;
    logic               r_out_valid;
    t_status            r_out_status;
    logic [START_W-1:0] r_out_start;
    logic [LEN_W-1:0]   r_out_len;

    logic               accept;
    logic               issue;
    logic               step;
    logic               out_free;
    logic               id_ok;
    logic [CW-1:0]      n_now;
    logic [DW-1:0]      mem_rdata;
    logic               mem_we;
    logic [DW-1:0]      mem_wdata;
    logic [DW-1:0]      search_key;
    t_run_flags         run_flags;
    logic [CW-1:0]      run_count;
    logic [CW-1:0]      run_count_next;
    logic [AW-1:0]      run_start;

    // Handshake and scan control
    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign issue    = (r_state == S_SCAN) && (r_idx < r_n);
    assign step     = (r_state == S_SCAN) && r_pend;
    assign out_free = !r_out_valid || !i_stall;

    // Managed count saturates at the table size
    assign n_now = (CMPW'(r_cfg) > CMPW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(r_cfg);
    assign id_ok = (int'(i_file_id) < NUM_FILE_IDS);

    assign search_key = (r_mode == MODE_ALLOC) ? FREE_KEY : r_id;
    assign mem_we     = (r_state == S_CLEAR) || (r_state == S_FILL);
    assign mem_wdata  = (r_state == S_CLEAR) ? FREE_KEY : r_id;

    cba_owner_mem #(
        .DEPTH (NUM_BLOCKS),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    cba_run_unit #(
        .AW (AW),
        .CW (CW),
        .DW (DW)
    ) u_run (
        .i_clk        (i_clk),
        .i_clr        (accept),
        .i_step       (step),
        .i_data       (mem_rdata),
        .i_key        (search_key),
        .i_idx        (r_chk_idx),
        .o_flags      (run_flags),
        .o_count      (run_count),
        .o_count_next (run_count_next),
        .o_start      (run_start)
    );

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_id         = r_id;
        n_size       = r_size;
        n_n          = r_n;
        n_idx        = r_idx;
        n_left       = r_left;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        n_res_len    = r_res_len;

        unique case (r_state)
            S_CLEAR: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_BLK) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (accept) begin
                    n_mode      = i_mode;
                    n_id        = DW'(i_file_id);
                    n_size      = CW'(i_size);
                    n_n         = n_now;
                    n_idx       = '0;
                    n_res_start = '0;
                    n_res_len   = '0;
                    n_state     = S_SCAN;
                    if (i_mode == MODE_ALLOC) begin
                        if (!id_ok || i_size == '0 || CMPW'(i_size) > CMPW'(n_now)) begin
                            n_res_status = ST_NO_SPACE;
                            n_state      = S_DONE;
                        end
                    end else begin
                        if (!id_ok || n_now == '0) begin
                            n_res_status = ST_NOT_FOUND;
                            n_state      = S_DONE;
                        end
                    end
                end
            end

            S_SCAN: begin
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_mode == MODE_ALLOC) begin
                    // first run of free blocks long enough
                    if (step && run_flags.match && run_count_next == r_size) begin
                        n_res_status = ST_CREATED;
                        n_res_start  = run_start;
                        n_res_len    = r_size;
                        n_idx        = CW'(run_start);
                        n_left       = r_size;
                        n_state      = S_FILL;
                    end else if (!r_pend && !issue) begin
                        n_res_status = ST_NO_SPACE;
                        n_state      = S_DONE;
                    end
                end else begin
                    // lowest run ends at the first mismatch or at the last managed block
                    if (step && !run_flags.match && !run_flags.first) begin
                        n_res_status = ST_FOUND;
                        n_res_start  = run_start;
                        n_res_len    = run_count;
                        n_state      = S_DONE;
                    end else if (!r_pend && !issue) begin
                        if (run_flags.first) begin
                            n_res_status = ST_NOT_FOUND;
                        end else begin
                            n_res_status = ST_FOUND;
                            n_res_start  = run_start;
                            n_res_len    = run_count;
                        end
                        n_state = S_DONE;
                    end
                end
            end

            S_FILL: begin
                n_idx  = r_idx + 1'b1;
                n_left = r_left - 1'b1;
                if (r_left == CW'(1)) begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_cfg       <= CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= issue;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_id         <= n_id;
        r_size       <= n_size;
        r_n          <= n_n;
        r_left       <= n_left;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        r_res_len    <= n_res_len;
        if (issue) begin
            r_chk_idx <= r_idx[AW-1:0];
        end
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_res_status;
            r_out_start  <= START_W'(r_res_start);
            r_out_len    <= LEN_W'(r_res_len);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_start_block = r_out_start;
    assign o_run_length  = r_out_len;

`ifndef SYNTHESIS
    // a taken item makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_stall)
        else $error("block not busy after taking an item");

    // run writes stay inside the managed blocks
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_idx < r_n && r_left != '0))
        else $error("run write outside managed blocks");

    // no result appears while the table is being cleared
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_valid)
        else $error("result during clearing pass");

    // a created run always has a length
    a_created_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_CREATED) |-> (o_run_length != '0))
        else $error("created run with zero length");
`endif

endmodule
